[design/tun_pkg.sv]
package tun_pkg;

	localparam int unsigned COORD_WIDTH_DEF   = 16;
	localparam int unsigned OUT_FRAC_BITS_DEF = 14;

	// width of a normalised magnitude
	localparam int unsigned NORM_BITS = 30;
	// sum of three squares of NORM_BITS values
	localparam int unsigned SUM_BITS = 2 * NORM_BITS + 2;
	// integer square root of SUM_BITS value
	localparam int unsigned ROOT_BITS = NORM_BITS + 1;

endpackage

[design/tun_if.sv]
interface tun_in_if #(
	parameter int unsigned CW = 16
);
	logic          valid;
	logic          ready;
	logic [CW-1:0] p_x, p_y, p_z, q_x, q_y, q_z, r_x, r_y, r_z;

	modport source (output valid, p_x, p_y, p_z, q_x, q_y, q_z, r_x, r_y, r_z, input ready);
	modport sink (input valid, p_x, p_y, p_z, q_x, q_y, q_z, r_x, r_y, r_z, output ready);
endinterface

interface tun_out_if #(
	parameter int unsigned OW = 16
);
	logic          valid;
	logic          ready;
	logic [OW-1:0] n_x, n_y, n_z;
	logic          degenerate;

	modport source (output valid, n_x, n_y, n_z, degenerate, input ready);
	modport sink (input valid, n_x, n_y, n_z, degenerate, output ready);
endinterface

[design/triangle_unit_normal_unit.sv]
// triangle unit normal, fully pipelined
// throughput: one item per cycle while the output is not stalled; the square root and the divides are unrolled one
// result bit per pipeline stage, so each root and divide stage is one add/compare wide
// a stalled output freezes the whole pipeline, nothing is lost or repeated
// reset clears all valid bits; payload registers are not reset
module triangle_unit_normal_unit
	import tun_pkg::*;
#(
	parameter int unsigned COORD_WIDTH   = COORD_WIDTH_DEF,
	parameter int unsigned OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	tun_in_if.sink    in_ch,
	tun_out_if.source out_ch
);

	localparam int unsigned DW   = COORD_WIDTH + 1;        // difference width
	localparam int unsigned PW   = 2 * DW;                 // product width
	localparam int unsigned CRW  = PW + 1;                 // cross component width
	localparam int unsigned MW   = CRW;                    // magnitude width (unsigned)
	localparam int unsigned LW   = $clog2(MW + 1);         // bit length width
	localparam int unsigned OW   = OUT_FRAC_BITS + 2;      // output width
	localparam int unsigned QB   = OUT_FRAC_BITS + 1;      // quotient bits (value <= 2^F)
	localparam int unsigned NUMW = NORM_BITS + OUT_FRAC_BITS + 1;
	localparam int unsigned RSTG = ROOT_BITS;              // root iterations
	localparam int unsigned NSTG = 7 + RSTG + QB;          // total stages
	localparam int unsigned XW   = (MW > NORM_BITS) ? MW : NORM_BITS;

	// global stall: everything advances when the output register is free
	logic adv;
	logic [NSTG-1:0] vld_q;
	assign adv          = !vld_q[NSTG-1] || out_ch.ready;
	assign in_ch.ready  = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NSTG-2:0], in_ch.valid};
		end
	end

	// stage 1: edge vectors
	logic signed [DW-1:0] u_s1 [3];
	logic signed [DW-1:0] v_s1 [3];
	always_ff @(posedge clk) begin
		if (adv) begin
			u_s1[0] <= DW'($signed(in_ch.p_x)) - DW'($signed(in_ch.q_x));
			u_s1[1] <= DW'($signed(in_ch.p_y)) - DW'($signed(in_ch.q_y));
			u_s1[2] <= DW'($signed(in_ch.p_z)) - DW'($signed(in_ch.q_z));
			v_s1[0] <= DW'($signed(in_ch.q_x)) - DW'($signed(in_ch.r_x));
			v_s1[1] <= DW'($signed(in_ch.q_y)) - DW'($signed(in_ch.r_y));
			v_s1[2] <= DW'($signed(in_ch.q_z)) - DW'($signed(in_ch.r_z));
		end
	end

	// stage 2: six products
	logic signed [PW-1:0] pa_s2 [3];
	logic signed [PW-1:0] pb_s2 [3];
	always_ff @(posedge clk) begin
		if (adv) begin
			pa_s2[0] <= u_s1[1] * v_s1[2];
			pb_s2[0] <= u_s1[2] * v_s1[1];
			pa_s2[1] <= u_s1[2] * v_s1[0];
			pb_s2[1] <= u_s1[0] * v_s1[2];
			pa_s2[2] <= u_s1[0] * v_s1[1];
			pb_s2[2] <= u_s1[1] * v_s1[0];
		end
	end

	// stage 3: cross components as sign and magnitude
	logic [MW-1:0] mag_s3 [3];
	logic [2:0]    neg_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				logic signed [CRW-1:0] c;
				c = CRW'(pa_s2[i]) - CRW'(pb_s2[i]);
				neg_s3[i] <= c[CRW-1];
				mag_s3[i] <= c[CRW-1] ? MW'(-c) : MW'(c);
			end
		end
	end

	// stage 4: bit length of the largest magnitude
	function automatic logic [LW-1:0] bitlen(input logic [MW-1:0] a);
		logic [LW-1:0] n;
		n = '0;
		for (int b = 0; b < MW; b++) begin
			if (a[b]) n = LW'(b + 1);
		end
		return n;
	endfunction

	logic [MW-1:0] mag_s4 [3];
	logic [2:0]    neg_s4;
	logic [LW-1:0] big_s4;
	always_ff @(posedge clk) begin
		if (adv) begin
			big_s4 <= bitlen(mag_s3[0] | mag_s3[1] | mag_s3[2]);
			mag_s4 <= mag_s3;
			neg_s4 <= neg_s3;
		end
	end

	// stage 5: normalise so the largest has NORM_BITS bits
	logic [NORM_BITS-1:0] m_s5 [3];
	logic [2:0]           neg_s5;
	logic                 deg_s5;
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				logic [XW-1:0] x;
				x = XW'(mag_s4[i]);
				if (big_s4 <= LW'(NORM_BITS))
					m_s5[i] <= NORM_BITS'(x << (LW'(NORM_BITS) - big_s4));
				else
					m_s5[i] <= NORM_BITS'(x >> (big_s4 - LW'(NORM_BITS)));
			end
			neg_s5 <= neg_s4;
			deg_s5 <= (big_s4 == '0);
		end
	end

	// stages 6 and 7: squares, then sum of squares
	logic [NORM_BITS-1:0] m_s6 [3];
	logic [2:0]           neg_s6;
	logic                 deg_s6;
	logic [SUM_BITS-1:0]  sq_s6 [3];
	logic [SUM_BITS-1:0]  sum_s7;
	logic [NORM_BITS-1:0] m_s7 [3];
	logic [2:0]           neg_s7;
	logic                 deg_s7;
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				sq_s6[i] <= SUM_BITS'(m_s5[i]) * SUM_BITS'(m_s5[i]);
			end
			m_s6   <= m_s5;
			neg_s6 <= neg_s5;
			deg_s6 <= deg_s5;
			sum_s7 <= sq_s6[0] + sq_s6[1] + sq_s6[2];
			m_s7   <= m_s6;
			neg_s7 <= neg_s6;
			deg_s7 <= deg_s6;
		end
	end

	// square root: one result bit per stage (restoring)
	logic [SUM_BITS-1:0]  rem_r [RSTG+1];
	logic [ROOT_BITS-1:0] root_r [RSTG+1];
	logic [NORM_BITS-1:0] m_r [RSTG+1][3];
	logic [2:0]           neg_r [RSTG+1];
	logic                 deg_r [RSTG+1];
	assign rem_r[0]  = sum_s7;
	assign root_r[0] = '0;
	assign m_r[0]    = m_s7;
	assign neg_r[0]  = neg_s7;
	assign deg_r[0]  = deg_s7;

	for (genvar k = 0; k < RSTG; k++) begin : g_root
		localparam int unsigned BP = 2 * (RSTG - 1 - k);
		logic [SUM_BITS+1:0] trial;
		logic [SUM_BITS+1:0] rw;
		always_comb begin
			rw    = (SUM_BITS + 2)'(root_r[k]);
			trial = (rw << (BP / 2 + 1)) + ((SUM_BITS + 2)'(1) << BP);
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				if ((SUM_BITS + 2)'(rem_r[k]) >= trial) begin
					rem_r[k+1]  <= rem_r[k] - SUM_BITS'(trial);
					root_r[k+1] <= root_r[k] | (ROOT_BITS'(1) << (RSTG - 1 - k));
				end else begin
					rem_r[k+1]  <= rem_r[k];
					root_r[k+1] <= root_r[k];
				end
				m_r[k+1]   <= m_r[k];
				neg_r[k+1] <= neg_r[k];
				deg_r[k+1] <= deg_r[k];
			end
		end
	end

	// rounded dividends and divisor
	logic [ROOT_BITS-1:0] len;
	assign len = root_r[RSTG];

	// divide: one quotient bit per stage for all three components
	logic [NUMW-1:0]      num_d [QB+1][3];
	logic [QB-1:0]        quo_d [QB+1][3];
	logic [ROOT_BITS-1:0] len_d [QB+1];
	logic [2:0]           neg_d [QB+1];
	logic                 deg_d [QB+1];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num_d[0][i] = (NUMW'(m_r[RSTG][i]) << OUT_FRAC_BITS) + NUMW'(len >> 1);
			quo_d[0][i] = '0;
		end
	end
	assign len_d[0] = len;
	assign neg_d[0] = neg_r[RSTG];
	assign deg_d[0] = deg_r[RSTG];

	for (genvar k = 0; k < QB; k++) begin : g_div
		localparam int unsigned QP = QB - 1 - k;
		always_ff @(posedge clk) begin
			if (adv) begin
				for (int i = 0; i < 3; i++) begin
					logic [NUMW+QB-1:0] t;
					t = (NUMW + QB)'(len_d[k]) << QP;
					if ((NUMW + QB)'(num_d[k][i]) >= t) begin
						num_d[k+1][i] <= num_d[k][i] - NUMW'(t);
						quo_d[k+1][i] <= quo_d[k][i] | (QB'(1) << QP);
					end else begin
						num_d[k+1][i] <= num_d[k][i];
						quo_d[k+1][i] <= quo_d[k][i];
					end
				end
				len_d[k+1] <= len_d[k];
				neg_d[k+1] <= neg_d[k];
				deg_d[k+1] <= deg_d[k];
			end
		end
	end

	// output: sign and degenerate case
	always_comb begin
		logic [OW-1:0] n [3];
		for (int i = 0; i < 3; i++) begin
			n[i] = OW'(quo_d[QB][i]);
			if (deg_d[QB])
				n[i] = '0;
			else if (neg_d[QB][i])
				n[i] = -n[i];
		end
		out_ch.n_x        = n[0];
		out_ch.n_y        = n[1];
		out_ch.n_z        = n[2];
		out_ch.degenerate = deg_d[QB];
		out_ch.valid      = vld_q[NSTG-1];
	end

	// a stalled result must stay valid and keep n_x
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.n_x))
		else $error("result changed under stall");
	// degenerate results have zero n_x and n_z
	a_deg: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.degenerate |-> out_ch.n_x == '0 && out_ch.n_z == '0)
		else $error("degenerate result not zero");
	// input is ready whenever no result is pending
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!out_ch.valid |-> in_ch.ready)
		else $error("stall without pending result");

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
	import tun_pkg::*;

	localparam int CW = COORD_WIDTH_DEF;
	localparam int FB = OUT_FRAC_BITS_DEF;
	localparam int OW = FB + 2;
	// pipeline depth, matching NSTG of the top level
	localparam int LATENCY = 7 + NORM_BITS + 1 + FB + 1;
	localparam int WATCHDOG = 4000;
	localparam int N_RANDOM = 2000;

	typedef logic signed [CW-1:0] coord_t;
	typedef struct {
		coord_t c[9];
	} tri_t;
	typedef struct {
		logic [OW-1:0] x, y, z;
		logic degen;
	} normal_t;
	// directed row: points, a typed-in normal where obvious
	typedef struct {
		tri_t t;
		bit has_exp;
		normal_t n;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tun_in_if #(.CW(CW)) in_ch ();
	tun_out_if #(.OW(OW)) out_ch ();

	triangle_unit_normal_unit #(.COORD_WIDTH(CW), .OUT_FRAC_BITS(FB)) dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	normal_t pending_normals[$];
	int errors = 0;
	int idle_cycles = 0;
	bit stim_done = 0;
	bit hold_off = 0;

	task automatic report(input string what, input logic [OW-1:0] got, input logic [OW-1:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// unit normal of the triangle: exact cross product, normalise to 30 bits, divide
	function automatic normal_t face_normal(input tri_t t);
		logic signed [17:0] u[3], w[3];
		logic signed [67:0] cr[3];
		logic [67:0] mag[3];
		logic [63:0] m[3], s, len, q;
		logic [OW-1:0] o[3];
		int big, bl;
		normal_t n;
		for (int i = 0; i < 3; i++) begin
			u[i] = 18'(t.c[i]) - 18'(t.c[3+i]);
			w[i] = 18'(t.c[3+i]) - 18'(t.c[6+i]);
		end
		cr[0] = 68'(u[1]) * 68'(w[2]) - 68'(u[2]) * 68'(w[1]);
		cr[1] = 68'(u[2]) * 68'(w[0]) - 68'(u[0]) * 68'(w[2]);
		cr[2] = 68'(u[0]) * 68'(w[1]) - 68'(u[1]) * 68'(w[0]);
		big = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = cr[i][67] ? 68'(-cr[i]) : 68'(cr[i]);
			bl = 0;
			for (int k = 0; k < 68; k++) if (mag[i][k]) bl = k + 1;
			if (bl > big) big = bl;
		end
		if (big == 0) begin
			n.x = '0; n.y = '0; n.z = '0; n.degen = 1'b1;
			return n;
		end
		s = 0;
		for (int i = 0; i < 3; i++) begin
			if (big <= NORM_BITS) m[i] = 64'(mag[i] << (NORM_BITS - big));
			else m[i] = 64'(mag[i] >> (big - NORM_BITS));
			s = s + m[i] * m[i];
		end
		len = int_sqrt(s);
		for (int i = 0; i < 3; i++) begin
			q = ((m[i] << FB) + (len >> 1)) / len;
			if (q > (64'd1 << FB)) q = 64'd1 << FB;
			o[i] = cr[i][67] ? OW'(-q) : OW'(q);
		end
		n.x = o[0]; n.y = o[1]; n.z = o[2]; n.degen = 1'b0;
		return n;
	endfunction

	function automatic tri_t rand_tri(input int mode);
		tri_t t;
		for (int i = 0; i < 9; i++) begin
			case (mode)
				0: t.c[i] = coord_t'($urandom);
				1: t.c[i] = coord_t'($urandom_range(0, 8) - 4);
				default: t.c[i] = coord_t'($urandom_range(0, 1) ? 16'h7fff - $urandom_range(0, 3)
					: 16'h8000 + $urandom_range(0, 3));
			endcase
		end
		// occasionally collinear: R = Q + (Q - P) keeps the line when in range
		if (mode == 0 && $urandom_range(0, 9) == 0) begin
			for (int i = 0; i < 3; i++) begin
				t.c[i] = coord_t'($urandom_range(0, 4000) - 2000);
				t.c[3+i] = coord_t'($urandom_range(0, 4000) - 2000);
				t.c[6+i] = coord_t'(2 * t.c[3+i] - t.c[i]);
			end
		end
		return t;
	endfunction

	function automatic tri_t mk(input int a[9]);
		tri_t t;
		for (int i = 0; i < 9; i++) t.c[i] = coord_t'(a[i]);
		return t;
	endfunction

	row_t rows[$];
	tri_t drive_q[$];

	// sender: bursts and gaps, payload changes on the falling edge
	task automatic send(input tri_t t);
		in_ch.valid <= 1'b1;
		{in_ch.p_x, in_ch.p_y, in_ch.p_z} <= {t.c[0], t.c[1], t.c[2]};
		{in_ch.q_x, in_ch.q_y, in_ch.q_z} <= {t.c[3], t.c[4], t.c[5]};
		{in_ch.r_x, in_ch.r_y, in_ch.r_z} <= {t.c[6], t.c[7], t.c[8]};
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic add_row(input int a[9], input bit he, input normal_t n);
		row_t r;
		r.t = mk(a);
		r.has_exp = he;
		r.n = n;
		rows.push_back(r);
	endtask

	initial begin
		normal_t none, ex, ey, ez, degen;
		int burst;
		none = '{default: '0};
		ex = '{x: OW'(1 << FB), y: '0, z: '0, degen: 1'b0};
		ey = '{x: '0, y: OW'(1 << FB), z: '0, degen: 1'b0};
		ez = '{x: '0, y: '0, z: OW'(-(1 << FB)), degen: 1'b0};
		degen = '{x: '0, y: '0, z: '0, degen: 1'b1};
		in_ch.valid = 1'b0;
		{in_ch.p_x, in_ch.p_y, in_ch.p_z, in_ch.q_x, in_ch.q_y, in_ch.q_z} = '0;
		{in_ch.r_x, in_ch.r_y, in_ch.r_z} = '0;

		// coincident points, collinear points, axis normals, extremes
		add_row('{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, degen);
		add_row('{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767}, 1, degen);
		add_row('{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
			-32768}, 1, degen);
		add_row('{0, 0, 0, 256, 256, 256, 512, 512, 512}, 1, degen);
		add_row('{-32768, -32768, -32768, 0, 0, 0, 32767, 32767, 32767}, 0, none);
		// u = (-1,0,0), v = (0,-1,0) gives +z; swapped order gives -z
		add_row('{0, 0, 0, 256, 0, 0, 256, 256, 0}, 0, none);
		add_row('{0, 0, 0, 0, 256, 0, 256, 256, 0}, 1, ez);
		// u = (0,-1,0), v = (0,0,-1) gives +x
		add_row('{0, 0, 0, 0, 1, 0, 0, 1, 1}, 1, ex);
		// u = (0,0,-1), v = (-1,0,0) gives +y
		add_row('{0, 0, 0, 0, 0, 1, 1, 0, 1}, 1, ey);
		add_row('{32767, -32768, 32767, -32768, 32767, -32768, 32767, 32767, -32768}, 0, none);
		add_row('{-32768, 32767, 0, 32767, -32768, 0, 0, 0, 32767}, 0, none);
		add_row('{32767, 0, 0, 0, 32767, 0, 0, 0, 32767}, 0, none);
		add_row('{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768}, 0, none);
		add_row('{1, 0, 0, 0, 1, 0, 0, 0, 0}, 0, none);
		add_row('{1, 2, 3, -4, 5, -6, 7, -8, 9}, 0, none);
		add_row('{-1, -1, -1, 0, 0, 0, 1, 2, 0}, 0, none);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table, running straight on into the random part
		foreach (rows[i]) begin
			pending_normals.push_back(rows[i].has_exp ? rows[i].n : face_normal(rows[i].t));
			send(rows[i].t);
		end

		// random part, bursts with gaps; some stretches run flat out
		for (int n = 0; n < N_RANDOM; ) begin
			burst = $urandom_range(1, 40);
			for (int b = 0; b < burst && n < N_RANDOM; b++, n++) begin
				tri_t t;
				t = rand_tri($urandom_range(0, 9) < 7 ? 0 : $urandom_range(1, 2));
				pending_normals.push_back(face_normal(t));
				send(t);
			end
			if ($urandom_range(0, 3) != 0) begin
				in_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
		end
		in_ch.valid <= 1'b0;
		stim_done = 1;
	end

	// receiver: stall pattern plus one long hold-off so the pipe fills
	initial begin
		int phase;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		phase = 0;
		forever begin
			if (phase == 300) begin
				hold_off = 1;
				out_ch.ready <= 1'b0;
				repeat (3 * LATENCY) @(negedge clk);
				hold_off = 0;
			end
			if (phase % 500 < 150) out_ch.ready <= 1'b1;
			else out_ch.ready <= ($urandom_range(0, 3) != 0);
			phase++;
			@(negedge clk);
		end
	end

	// result checking at the rising edge
	always @(posedge clk) begin
		normal_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_normals.size() == 0) begin
				report("unexpected transfer", out_ch.n_x, '0);
			end else begin
				want = pending_normals.pop_front();
				if (out_ch.n_x !== want.x) report("n_x", out_ch.n_x, want.x);
				if (out_ch.n_y !== want.y) report("n_y", out_ch.n_y, want.y);
				if (out_ch.n_z !== want.z) report("n_z", out_ch.n_z, want.z);
				if (out_ch.degenerate !== want.degen)
					report("degenerate", OW'(out_ch.degenerate), OW'(want.degen));
			end
		end
	end

	// watchdog over cycles without any transfer
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || hold_off)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// wind-down: drain, then let the pipe settle for any stray result
	initial begin
		wait (stim_done);
		wait (pending_normals.size() == 0);
		repeat (2 * LATENCY) @(posedge clk);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
